/* hdl/tbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, register indexes and constants for the two-button press
// length classifier.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int CntW      = 16;
    localparam int PresW     = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 8;

    localparam logic [CntW-1:0]  CntMax        = 16'hFFFF;
    localparam logic [CntW-1:0]  DecayBigLevel = 16'd50;
    localparam logic [CntW-1:0]  DecayBigStep  = 16'd50;
    localparam logic [CntW-1:0]  DecayMidLevel = 16'd10;
    localparam logic [CntW-1:0]  DecayMidStep  = 16'd5;
    localparam logic [CntW-1:0]  AccelStep     = 16'd10;

    localparam logic [PresW-1:0] SamplePeriodRst   = 8'd5;
    localparam logic [CntW-1:0]  LongThresholdRst  = 16'd1000;
    localparam logic [CntW-1:0]  HalfThresholdRst  = 16'd50;
    localparam logic [CntW-1:0]  ShortThresholdRst = 16'd10;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ACCEL_MODE      = 3'd0,
        REG_SAMPLE_PERIOD   = 3'd1,
        REG_LONG_THRESHOLD  = 3'd2,
        REG_HALF_THRESHOLD  = 3'd3,
        REG_SHORT_THRESHOLD = 3'd4
    } reg_idx_t;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_POLL = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_HALF  = 2'd2,
        CLS_LONG  = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_UP    = 2'd1,
        ACT_ENTER = 2'd2,
        ACT_BACK  = 2'd3
    } act_t;

    typedef struct packed {
        logic             accel_mode;
        logic [PresW-1:0] sample_period;
        logic [CntW-1:0]  long_threshold;
        logic [CntW-1:0]  half_threshold;
        logic [CntW-1:0]  short_threshold;
    } cfg_t;

    // action in the low bits, second_class above
    typedef struct packed {
        cls_t second_class;
        act_t action;
    } result_t;

    function automatic logic [CntW-1:0] sample_one(input logic [CntW-1:0] cnt,
                                                   input logic held);
        logic [CntW-1:0] res;
        if (held)
            res = (cnt == CntMax) ? CntMax : cnt + 16'd1;
        else if (cnt > DecayBigLevel)
            res = cnt - DecayBigStep;
        else if (cnt > DecayMidLevel)
            res = cnt - DecayMidStep;
        else if (cnt != '0)
            res = cnt - 16'd1;
        else
            res = '0;
        return res;
    endfunction

endpackage

/* hdl/tbp_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_cfg
// Configuration register file: decodes indexed writes into the settings.
// ----------------------------------------------------------------------------
module tbp_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbp_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tbp_pkg::CfgDataW-1:0]  cfg_data,
    output tbp_pkg::cfg_t                 cfg
);
    import tbp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACCEL_MODE:      cfg_next.accel_mode      = cfg_data[0];
                REG_SAMPLE_PERIOD:   cfg_next.sample_period   = cfg_data[PresW-1:0];
                REG_LONG_THRESHOLD:  cfg_next.long_threshold  = cfg_data[CntW-1:0];
                REG_HALF_THRESHOLD:  cfg_next.half_threshold  = cfg_data[CntW-1:0];
                REG_SHORT_THRESHOLD: cfg_next.short_threshold = cfg_data[CntW-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_mode      <= 1'b0;
            cfg_reg.sample_period   <= SamplePeriodRst;
            cfg_reg.long_threshold  <= LongThresholdRst;
            cfg_reg.half_threshold  <= HalfThresholdRst;
            cfg_reg.short_threshold <= ShortThresholdRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/tbp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_core
// Prescaler and press counters; updates state and forms the result of one
// word per cycle.
// ----------------------------------------------------------------------------
module tbp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbp_pkg::cfg_t     cfg,
    input  logic              in_fire,
    input  logic              in_mode,
    input  logic              in_first,
    input  logic              in_second,
    output tbp_pkg::result_t  res
);
    import tbp_pkg::*;

    logic [PresW-1:0] prescale_reg, prescale_next;
    logic [CntW-1:0]  first_reg, first_next;
    logic [CntW-1:0]  second_reg, second_next;
    logic [PresW-1:0] pres_dec;
    cls_t             cls;
    act_t             act;

    assign pres_dec = (prescale_reg != '0) ? prescale_reg - 8'd1 : '0;

    always_comb
    begin
        cls = CLS_NONE;
        if (!cfg.accel_mode)
        begin
            if (second_reg > cfg.long_threshold)
                cls = CLS_LONG;
            else if (second_reg > cfg.half_threshold)
                cls = CLS_HALF;
            else if (second_reg > cfg.short_threshold)
                cls = CLS_SHORT;
        end
        else if (second_reg > cfg.short_threshold)
        begin
            cls = CLS_SHORT;
        end

        act = (first_reg > cfg.short_threshold) ? ACT_UP : ACT_NONE;
        if (cls == CLS_LONG)
            act = ACT_BACK;
        else if (cls != CLS_NONE)
            act = ACT_ENTER;
    end

    always_comb
    begin
        prescale_next    = prescale_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        res.action       = ACT_NONE;
        res.second_class = CLS_NONE;
        if (in_fire)
        begin
            if (in_mode == MODE_TICK)
            begin
                if (pres_dec == '0)
                begin
                    first_next    = sample_one(first_reg, in_first);
                    second_next   = sample_one(second_reg, in_second);
                    prescale_next = cfg.sample_period;
                end
                else
                begin
                    prescale_next = pres_dec;
                end
            end
            else
            begin
                res.action       = act;
                res.second_class = cls;
                if (cfg.accel_mode && (cls == CLS_SHORT))
                    second_next = (second_reg > AccelStep) ? second_reg - AccelStep : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
        end
    end

    a_poll_keeps_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_mode == MODE_POLL) |=> $stable(prescale_reg))
        else $error("poll changed prescaler");

    a_poll_keeps_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_mode == MODE_POLL) |=> $stable(first_reg))
        else $error("poll changed first counter");

    a_plain_poll_keeps_second: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_mode == MODE_POLL && !cfg.accel_mode) |=> $stable(second_reg))
        else $error("plain poll changed second counter");

endmodule

/* hdl/tbp_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_skid
// Output register with a skid stage; holds results while the sink stalls.
// ----------------------------------------------------------------------------
module tbp_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbp_pkg::result_t  push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tbp_pkg::result_t  out_data
);
    import tbp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled push not held in skid");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word not moved to output");

endmodule

/* hdl/two_button_press_length_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_press_length_classifier_top
// Two-button press length classifier with sample prescaler, decaying press
// counters and poll-time classification into menu actions.
//
//   channel  handshake             payload
//   s_*      s_tvalid / s_tready   tdata: first, second pressed; tuser: mode
//   m_*      m_tvalid / m_tready   tdata: action, second_class
//   cfg_*    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word per cycle unless m_tready stalls; results go to the output or skid
// register. Counter and prescaler update and poll compares are combinational.
// A skid stage keeps s_tready high for one extra word while m_tready is low.
// Reset clears counters and prescaler and loads register defaults.
// ----------------------------------------------------------------------------
module two_button_press_length_classifier_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tbp_pkg::InDataW-1:0]   s_tdata,   // [0] first_pressed, [1] second_pressed
    input  logic                          s_tuser,   // [0] mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tbp_pkg::OutDataW-1:0]  m_tdata,   // [1:0] action, [3:2] second_class
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbp_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tbp_pkg::CfgDataW-1:0]  cfg_data
);
    import tbp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    in_fire;

    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_res};

    tbp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_mode   (s_tuser),
        .in_first  (s_tdata[0]),
        .in_second (s_tdata[1]),
        .res       (res)
    );

    tbp_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

endmodule
